### design/elpi_pkg.sv
// shared types, constants and tables for the leaky intensity unit
`default_nettype none
package elpi_pkg;

  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 512;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PIX_W        = $clog2(PIX_COUNT);

  localparam logic signed [33:0] VAL_MAX = 34'sd8388607;
  localparam logic signed [33:0] VAL_MIN = -34'sd8388608;

  // exponent in 1/64 units is rate*elapsed/15625; x >= 1024 past this product
  localparam logic [39:0] EXP_PROD = 40'd16000000;
  localparam logic [23:0] DIV_C    = 24'd15625;
  localparam logic [24:0] RECIP    = 25'd17592187;  // ceil(2^38 / 15625)
  localparam int          RECIP_SH = 38;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [1:0] {
    K_EVENT = 2'd0,
    K_SWEEP = 2'd1,
    K_SKIP  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [31:0]      ts;
    logic [PIX_W-1:0] idx;
    logic             pol;
  } item_t;

  typedef struct packed {
    logic  empty;
    item_t item;
  } fq_t;

  // exp(-2^k/64) in Q0.16
  function automatic logic [15:0] decay_tbl(input logic [3:0] k);
    logic [15:0] r;
    case (k)
      4'd0: r = 16'd64520;
      4'd1: r = 16'd63520;
      4'd2: r = 16'd61565;
      4'd3: r = 16'd57835;
      4'd4: r = 16'd51039;
      4'd5: r = 16'd39750;
      4'd6: r = 16'd24109;
      4'd7: r = 16'd8869;
      4'd8: r = 16'd1200;
      4'd9: r = 16'd22;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/event_pixel_leaky_intensity_unit.sv
// top level of the per-pixel leaky log-intensity unit with its register port
`default_nettype none
// Per-pixel leaky log-intensity reconstruction for a 1024 x 512 event sensor.
// Each pixel holds a signed Q8.16 value and the time of its last update, both
// in on-chip memories. A pixel event (cmd 0) decays the pixel by
// exp(-decay_rate * elapsed), subtracts contrast_step for positive polarity or
// adds it for negative, saturates, stores the time and returns the value. An
// event outside the frame gives a zero result and touches nothing. A sweep
// (cmd 1) decays every pixel to the given time and returns one result with
// sweep_done set. After reset the block runs a clearing pass over all 524288
// pixels, one a cycle, with full held high; register writes are taken as ever.
// Items are handled one at a time by a read-decay-write sequencer. A pixel
// event goes through dispatch, one memory read, an exponent stage, ten table
// multiply steps and a done state in the decay unit, one scaling multiply and
// one write; the table steps are left out when the exponent is large enough
// that the decay is total. An event outside the frame is answered at dispatch.
// A sweep runs the same steps for every pixel after one dispatch. A two-item
// input queue and one result register let the sides stall independently.
// Registers: contrast_step at 0x0, decay_rate at 0x4.
module event_pixel_leaky_intensity_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // item input
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd,
  input  wire logic [31:0] timestamp,
  input  wire logic [9:0]  pixel_x,
  input  wire logic [8:0]  pixel_y,
  input  wire logic        polarity,
  // result output
  output logic             empty,
  input  wire logic        pop,
  output logic signed [31:0] pixel_value,
  output logic             value_saturated,
  output logic             sweep_done,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import elpi_pkg::*;

  localparam logic REG_STEP = 1'b0;
  localparam logic REG_RATE = 1'b1;

  logic [15:0] contrast_step;
  logic [7:0]  decay_rate;
  fq_t         fq;
  logic        fq_pop;
  logic        clearing;
  logic [31:0] value_bits;

  // register port, always ready
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      contrast_step <= 16'd6554;
      decay_rate    <= 8'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_STEP: contrast_step <= pwdata[15:0];
        REG_RATE: decay_rate    <= pwdata[7:0];
        default:  contrast_step <= contrast_step;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_STEP: prdata = {16'd0, contrast_step};
      REG_RATE: prdata = {24'd0, decay_rate};
      default:  prdata = 32'd0;
    endcase
  end

  // front: classify and queue items
  elpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .timestamp (timestamp),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .polarity  (polarity),
    .clearing  (clearing),
    .fq_pop    (fq_pop),
    .fq        (fq)
  );

  // back: memories, decay and update
  elpi_back u_back (
    .clk             (clk),
    .rst             (rst),
    .fq              (fq),
    .fq_pop          (fq_pop),
    .clearing        (clearing),
    .contrast_step   (contrast_step),
    .decay_rate      (decay_rate),
    .empty           (empty),
    .pop             (pop),
    .pixel_value     (value_bits),
    .value_saturated (value_saturated),
    .sweep_done      (sweep_done)
  );

  assign pixel_value = signed'(value_bits);

endmodule
`default_nettype wire

### design/elpi_front.sv
// front end: classifies items and holds them in a two-entry queue
`default_nettype none
module elpi_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              cmd,
  input  wire logic [31:0]       timestamp,
  input  wire logic [9:0]        pixel_x,
  input  wire logic [8:0]        pixel_y,
  input  wire logic              polarity,
  input  wire logic              clearing,
  input  wire logic              fq_pop,
  output elpi_pkg::fq_t          fq
);
  import elpi_pkg::*;

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  item_t       new_item;
  logic        in_frame;
  logic        do_push;
  logic        do_pop;

  assign in_frame = (32'(pixel_x) < 32'(FRAME_WIDTH)) && (32'(pixel_y) < 32'(FRAME_HEIGHT));

  always_comb begin
    new_item.ts  = timestamp;
    new_item.pol = polarity;
    new_item.idx = PIX_W'(PIX_W'(pixel_y) * PIX_W'(FRAME_WIDTH)) + PIX_W'(pixel_x);
    if (cmd) begin
      new_item.kind = K_SWEEP;
    end else if (in_frame) begin
      new_item.kind = K_EVENT;
    end else begin
      new_item.kind = K_SKIP;
    end
  end

  assign full     = clearing || (count == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = fq_pop && (count != 2'd0);
  assign fq.empty = (count == 2'd0);
  assign fq.item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

### design/elpi_decay.sv
// decay factor unit: exponent from elapsed time, then table product one bit a cycle
`default_nettype none
module elpi_decay (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] elapsed,
  input  wire logic [7:0]  decay_rate,
  output logic             done,
  output logic [16:0]      factor
);
  import elpi_pkg::*;

  typedef enum logic [5:0] {
    D_IDLE = 6'b000001,
    D_DIV  = 6'b000010,
    D_QUO  = 6'b000100,
    D_FIX  = 6'b001000,
    D_ITER = 6'b010000,
    D_DONE = 6'b100000
  } dstate_t;

  dstate_t     state;
  logic [39:0] prod;
  logic        big;
  logic [48:0] pm;
  logic [10:0] quo;
  logic [9:0]  xexp;
  logic [3:0]  k;
  logic [32:0] fmul;
  logic [23:0] qm;

  assign qm   = 24'(quo) * DIV_C;
  assign fmul = 33'(factor) * 33'(decay_tbl(k)) + 33'd32768;
  assign done = (state == D_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: if (start) state <= D_DIV;
        D_DIV:  state <= D_QUO;
        D_QUO:  state <= D_FIX;
        D_FIX:  state <= big ? D_DONE : D_ITER;
        D_ITER: if (k == 4'd9) state <= D_DONE;
        D_DONE: state <= D_IDLE;
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        prod <= 40'(decay_rate) * 40'(elapsed);
      end
      D_DIV: begin
        big <= prod >= EXP_PROD;
        pm  <= 49'(prod[23:0]) * 49'(RECIP);
      end
      D_QUO: begin
        quo <= pm[48:RECIP_SH];
      end
      D_FIX: begin
        // reciprocal may overshoot by one
        xexp   <= (qm > prod[23:0]) ? 10'(quo - 11'd1) : quo[9:0];
        factor <= big ? 17'd0 : ONE_Q16;
        k      <= 4'd0;
      end
      D_ITER: begin
        if (xexp[k]) begin
          factor <= fmul[32:16];
        end
        k <= k + 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### design/elpi_back.sv
// back end: pixel stores, clearing pass, read-decay-update-write sequencer, result register
`default_nettype none
module elpi_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire elpi_pkg::fq_t fq,
  output logic             fq_pop,
  output logic             clearing,
  input  wire logic [15:0] contrast_step,
  input  wire logic [7:0]  decay_rate,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      pixel_value,
  output logic             value_saturated,
  output logic             sweep_done
);
  import elpi_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_ELAP  = 7'b0001000,
    S_FACT  = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_FIN   = 7'b1000000
  } bstate_t;

  bstate_t          state;
  item_t            cur;
  logic [PIX_W-1:0] idx;
  logic [31:0]      val_mem  [PIX_COUNT];
  logic [31:0]      time_mem [PIX_COUNT];
  logic [31:0]      rd_val;
  logic [31:0]      rd_time;
  logic             mem_we;
  logic [31:0]      wr_val;
  logic [31:0]      wr_time;
  logic             dec_start;
  logic             dec_done;
  logic [16:0]      dec_factor;
  logic [31:0]      elapsed;
  logic [31:0]      mag;
  logic [48:0]      mprod;
  logic [31:0]      dmag;
  logic             neg;
  logic [31:0]      dval;
  logic signed [33:0] sum;
  logic [31:0]      ev_val;
  logic             ev_sat;
  logic             out_valid;
  logic             last_idx;

  assign clearing  = (state == S_CLEAR);
  assign last_idx  = (idx == PIX_W'(PIX_COUNT - 1));
  assign fq_pop    = (state == S_IDLE) && !fq.empty && !out_valid;
  assign dec_start = (state == S_ELAP);
  assign elapsed   = (cur.ts >= rd_time) ? (cur.ts - rd_time) : 32'd0;
  assign mag       = rd_val[31] ? (32'd0 - rd_val) : rd_val;
  assign mprod     = 49'(mag) * 49'(dec_factor) + 49'd32768;
  assign dval      = neg ? (32'd0 - dmag) : dmag;
  assign sum       = cur.pol ? (34'(signed'(dval)) - 34'(contrast_step))
                             : (34'(signed'(dval)) + 34'(contrast_step));

  always_comb begin
    ev_sat = 1'b1;
    if (sum > VAL_MAX) begin
      ev_val = 32'(VAL_MAX);
    end else if (sum < VAL_MIN) begin
      ev_val = 32'(VAL_MIN);
    end else begin
      ev_val = sum[31:0];
      ev_sat = 1'b0;
    end
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_val  = 32'd0;
    wr_time = 32'd0;
    case (state)
      S_CLEAR: mem_we = 1'b1;
      S_FIN: begin
        mem_we  = 1'b1;
        wr_time = cur.ts;
        wr_val  = (cur.kind == K_SWEEP) ? dval : ev_val;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      val_mem[idx]  <= wr_val;
      time_mem[idx] <= wr_time;
    end
    rd_val  <= val_mem[idx];
    rd_time <= time_mem[idx];
  end

  elpi_decay u_decay (
    .clk        (clk),
    .rst        (rst),
    .start      (dec_start),
    .elapsed    (elapsed),
    .decay_rate (decay_rate),
    .done       (dec_done),
    .factor     (dec_factor)
  );

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + PIX_W'(1);
          if (last_idx) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (fq_pop) begin
            cur <= fq.item;
            case (fq.item.kind)
              K_EVENT: begin
                idx   <= fq.item.idx;
                state <= S_READ;
              end
              K_SWEEP: begin
                idx   <= '0;
                state <= S_READ;
              end
              default: begin
                out_valid       <= 1'b1;
                pixel_value     <= 32'd0;
                value_saturated <= 1'b0;
                sweep_done      <= 1'b0;
              end
            endcase
          end
        end
        S_READ: state <= S_ELAP;
        S_ELAP: state <= S_FACT;
        S_FACT: if (dec_done) state <= S_MUL;
        S_MUL: begin
          dmag  <= mprod[47:16];
          neg   <= rd_val[31];
          state <= S_FIN;
        end
        S_FIN: begin
          if (cur.kind == K_SWEEP) begin
            if (last_idx) begin
              out_valid       <= 1'b1;
              pixel_value     <= 32'd0;
              value_saturated <= 1'b0;
              sweep_done      <= 1'b1;
              state           <= S_IDLE;
            end else begin
              idx   <= idx + PIX_W'(1);
              state <= S_READ;
            end
          end else begin
            out_valid       <= 1'b1;
            pixel_value     <= ev_val;
            value_saturated <= ev_sat;
            sweep_done      <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/elpi_checker.sv
// port-level checker for the leaky intensity unit and its bind
`default_nettype none
module elpi_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic signed [31:0] pixel_value,
  input wire logic              value_saturated,
  input wire logic              sweep_done
);

  // clearing pass blocks input right after reset
  a_full_after_rst: assert property (@(posedge clk) rst |=> full)
    else $error("input open right after reset");

  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_sweep_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && sweep_done) |-> (pixel_value == 32'sd0 && !value_saturated))
    else $error("sweep result carries a value");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (!empty && value_saturated) |->
      (pixel_value == 32'sd8388607 || pixel_value == -32'sd8388608))
    else $error("saturated value not at a range bound");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel_value) && $stable(sweep_done)))
    else $error("waiting result changed");

endmodule

bind event_pixel_leaky_intensity_unit elpi_checker u_elpi_checker (
  .clk             (clk),
  .rst             (rst),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .pixel_value     (pixel_value),
  .value_saturated (value_saturated),
  .sweep_done      (sweep_done)
);
`default_nettype wire
